### rtl/core/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg: shared types and constants of the particle Euler step block
// Holds field widths, register indexes, reset values and the queue payload.
// ----------------------------------------------------------------------------
package pes_pkg;

	localparam int POS_W = 32;
	localparam int TS_W = 24;
	localparam int BOX_W = 31;
	localparam int RAD_W = 31;
	localparam int INVM_W = 32;
	localparam int EN_W = 48;
	localparam int SQ_W = 64;
	localparam int CFG_W = 31;
	localparam int CFG_IDX_W = 1;
	localparam int IN_TDATA_W = 192;
	localparam int OUT_TDATA_W = 176;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HALF = 1'd1;

	localparam logic [TS_W-1:0] TIME_STEP_RST = 24'd1049;
	localparam logic [BOX_W-1:0] BOX_HALF_RST = 31'd33554432;

	localparam int MAX_PARTICLES_DEF = 4096;
	localparam int QUEUE_DEPTH_DEF = 2;

	// one accepted particle after classification in the front part
	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] vel_x;
		logic signed [POS_W-1:0] vel_y;
		logic [RAD_W-1:0] radius;
		logic [INVM_W-1:0] inv_mass;
		logic immovable;
		logic last_particle;
	} pes_item_t;

	// back part states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} pes_state_t;

endpackage

### rtl/core/particle_euler_step_with_energy_top.sv
// ----------------------------------------------------------------------------
// particle_euler_step_with_energy_top: Euler particle step with energy sum
// Advances one particle per transaction and reflects it at the box walls.
// ----------------------------------------------------------------------------
// usage:
// - slave stream s_*: one particle per transaction, tlast marks the last one
//   of a sweep; master stream m_*: one updated particle per transaction, tuser
//   bit 0 says tdata carries the completed energy sum, bit 1 that it saturated
// - cfg_we/cfg_idx/cfg_data write time_step (index 0) or box_half (index 1);
//   write only while no particle is in flight
// - a particle passes from acceptance to result through the queue, the
//   velocity and square products, the divider state (a start, 32 radix-4
//   steps of the 64-bit energy quotient and a check that it is done) and a
//   register for the result; a zero inverse mass skips the divider
// - the divider sets the rate: a new particle is taken only once the last
//   one is through; the input queue (two entries by default) absorbs bursts
// - reset clears the queue, the energy sum and its flag, and loads the
//   register defaults
// - a stalled receiver holds the result; the back part waits with the next
//   particle finished, and the queue fills then holds off the sender
// ----------------------------------------------------------------------------
module particle_euler_step_with_energy_top #(
	parameter int MAX_PARTICLES = pes_pkg::MAX_PARTICLES_DEF,
	parameter int QUEUE_DEPTH = pes_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [pes_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [pes_pkg::CFG_W-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// pos_x, pos_y, vel_x, vel_y, radius, inv_mass, one zero pad bit
	input  logic [pes_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	// new_pos_x, new_pos_y, new_vel_x, new_vel_y, energy_total
	output logic [pes_pkg::OUT_TDATA_W-1:0] m_tdata,
	// energy_valid, energy_saturated
	output logic [1:0] m_tuser
);

	logic [pes_pkg::TS_W-1:0] time_step_q;
	logic [pes_pkg::BOX_W-1:0] box_half_q;
	logic item_valid, item_ready;
	pes_pkg::pes_item_t item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= pes_pkg::TIME_STEP_RST;
			box_half_q <= pes_pkg::BOX_HALF_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				pes_pkg::REG_TIME_STEP: time_step_q <= cfg_data[pes_pkg::TS_W-1:0];
				pes_pkg::REG_BOX_HALF: box_half_q <= cfg_data[pes_pkg::BOX_W-1:0];
				default: ;
			endcase
		end
	end

	pes_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.item_valid(item_valid), .item_ready(item_ready), .item(item)
	);

	pes_back u_back (
		.clk(clk), .arst_n(arst_n),
		.time_step(time_step_q), .box_half(box_half_q),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	ast_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		MAX_PARTICLES >= 1) else $error("bad sweep bound");
	ast_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid) else $error("result withdrawn");
	ast_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_tready) |-> item_valid) else $error("queue blocks while empty");

endmodule

### rtl/core/pes_front.sv
// ----------------------------------------------------------------------------
// pes_front: input side of the particle Euler step block
// Unpacks the slave stream, flags immovable particles and feeds a short queue.
// ----------------------------------------------------------------------------
module pes_front #(
	parameter int QUEUE_DEPTH = pes_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// pos_x, pos_y, vel_x, vel_y, radius, inv_mass, one zero pad bit
	input  logic [pes_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic s_tlast,
	output logic item_valid,
	input  logic item_ready,
	output pes_pkg::pes_item_t item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pes_pkg::pes_item_t queue_q [QUEUE_DEPTH];
	pes_pkg::pes_item_t in_item;
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push, pop;

	// classify the incoming transaction
	always_comb begin
		in_item.pos_x = s_tdata[31:0];
		in_item.pos_y = s_tdata[63:32];
		in_item.vel_x = s_tdata[95:64];
		in_item.vel_y = s_tdata[127:96];
		in_item.radius = s_tdata[158:128];
		in_item.inv_mass = s_tdata[190:159];
		in_item.immovable = (s_tdata[190:159] == '0);
		in_item.last_particle = s_tlast;
	end

	assign s_tready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push = s_tvalid && s_tready;
	assign item_valid = (count_q != '0);
	assign pop = item_valid && item_ready;
	assign item = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	ast_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
	ast_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("push lost");
	ast_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop lost");

endmodule

### rtl/core/pes_div.sv
// ----------------------------------------------------------------------------
// pes_div: iterative unsigned divider
// Restoring radix-4 division of a 64-bit dividend by a 34-bit divisor,
// two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pes_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [pes_pkg::SQ_W-1:0] dividend,
	input  logic [pes_pkg::INVM_W+1:0] divisor,
	output logic busy,
	output logic done,
	output logic [pes_pkg::SQ_W-1:0] quotient
);

	localparam int DV_W = pes_pkg::INVM_W + 2;
	localparam int STEPS = pes_pkg::SQ_W / 2;
	localparam int STEP_W = $clog2(STEPS + 1);

	logic [DV_W+1:0] rem_q;
	logic [pes_pkg::SQ_W-1:0] quo_q;
	logic [DV_W-1:0] dsr_q;
	logic [STEP_W-1:0] steps_q;
	logic [DV_W+1:0] r1, r2, t1, t2;
	logic q1, q0;

	// two restoring steps per cycle
	always_comb begin
		r1 = {rem_q[DV_W:0], quo_q[pes_pkg::SQ_W-1]};
		t1 = r1 - {2'b00, dsr_q};
		q1 = !t1[DV_W+1];
		if (q1) begin
			r1 = t1;
		end
		r2 = {r1[DV_W:0], quo_q[pes_pkg::SQ_W-2]};
		t2 = r2 - {2'b00, dsr_q};
		q0 = !t2[DV_W+1];
		if (q0) begin
			r2 = t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			done <= 1'b0;
		end else begin
			done <= (steps_q == STEP_W'(1));
			if (start) begin
				steps_q <= STEP_W'(STEPS);
			end else if (steps_q != '0) begin
				steps_q <= steps_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (steps_q != '0) begin
			rem_q <= r2;
			quo_q <= {quo_q[pes_pkg::SQ_W-3:0], q1, q0};
		end
	end

	assign busy = (steps_q != '0);
	assign quotient = quo_q;

	ast_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without work");
	ast_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !start) else $error("restart while busy");
	ast_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rem_q < {2'b00, dsr_q})) else $error("remainder too large");

endmodule

### rtl/core/pes_back.sv
// ----------------------------------------------------------------------------
// pes_back: execution side of the particle Euler step block
// Integrates, reflects at the walls, accumulates energy and drives the output.
// ----------------------------------------------------------------------------
module pes_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [pes_pkg::TS_W-1:0] time_step,
	input  logic [pes_pkg::BOX_W-1:0] box_half,
	input  logic item_valid,
	output logic item_ready,
	input  pes_pkg::pes_item_t item,
	output logic m_tvalid,
	input  logic m_tready,
	// new_pos_x, new_pos_y, new_vel_x, new_vel_y, energy_total
	output logic [pes_pkg::OUT_TDATA_W-1:0] m_tdata,
	// energy_valid, energy_saturated
	output logic [1:0] m_tuser
);

	localparam int PW = pes_pkg::POS_W;
	localparam int EW = pes_pkg::EN_W;
	localparam logic signed [PW:0] SMAX = {2'b00, {(PW-1){1'b1}}};
	localparam logic signed [PW:0] SMIN = {2'b11, {(PW-1){1'b0}}};

	pes_pkg::pes_state_t state_q, state_d;
	pes_pkg::pes_item_t cur_q;
	logic signed [PW+pes_pkg::TS_W:0] dx_q, dy_q;
	logic [pes_pkg::SQ_W-1:0] sq_x_q, sq_y_q;
	logic [EW-1:0] sum_q;
	logic ovf_q;
	logic div_start, div_busy, div_done;
	logic [pes_pkg::SQ_W-1:0] quo;
	logic out_take;
	logic [PW-1:0] ax, ay;
	logic signed [PW-1:0] nx, ny, nvx, nvy;
	logic signed [PW+1:0] lo, hi;
	logic [EW:0] add_sum;
	logic [EW-1:0] sum_nx;
	logic ovf_nx;
	logic [PW-1:0] o_px_q, o_py_q, o_vx_q, o_vy_q;
	logic [EW-1:0] o_en_q;
	logic o_ev_q, o_es_q;

	// saturating negate
	function automatic logic signed [PW-1:0] neg_sat(input logic signed [PW-1:0] v);
		logic signed [PW:0] n;
		n = -{v[PW-1], v};
		neg_sat = (n > SMAX) ? SMAX[PW-1:0] : n[PW-1:0];
	endfunction

	// add displacement with floor shift and saturate
	function automatic logic signed [PW-1:0] adv(input logic signed [PW-1:0] p,
		input logic signed [PW+pes_pkg::TS_W:0] prod);
		logic signed [PW+pes_pkg::TS_W+1:0] s;
		s = p + (prod >>> 16);
		if (s > SMAX) adv = SMAX[PW-1:0];
		else if (s < SMIN) adv = SMIN[PW-1:0];
		else adv = s[PW-1:0];
	endfunction

	assign ax = cur_q.vel_x[PW-1] ? PW'(-cur_q.vel_x) : cur_q.vel_x;
	assign ay = cur_q.vel_y[PW-1] ? PW'(-cur_q.vel_y) : cur_q.vel_y;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pes_pkg::ST_IDLE: if (item_valid) state_d = pes_pkg::ST_MUL;
			pes_pkg::ST_MUL: state_d = pes_pkg::ST_DIV;
			pes_pkg::ST_DIV: if (div_done || cur_q.immovable) state_d = pes_pkg::ST_OUT;
			pes_pkg::ST_OUT: if (!m_tvalid || m_tready) state_d = pes_pkg::ST_IDLE;
			default: state_d = pes_pkg::ST_IDLE;
		endcase
	end

	// state outputs; the divider starts once the squares are registered
	always_comb begin
		item_ready = (state_q == pes_pkg::ST_IDLE);
		div_start = (state_q == pes_pkg::ST_DIV) && !cur_q.immovable && !div_busy && !div_done;
		out_take = (state_q == pes_pkg::ST_OUT) && (!m_tvalid || m_tready);
	end

	pes_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(sq_x_q + sq_y_q),
		.divisor({1'b0, cur_q.inv_mass, 1'b0}),
		.busy(div_busy), .done(div_done), .quotient(quo)
	);

	// position update, wall reflection and energy add
	always_comb begin
		lo = -$signed({3'b000, box_half}) + $signed({3'b000, cur_q.radius});
		hi = $signed({3'b000, box_half}) - $signed({3'b000, cur_q.radius});
		nx = adv(cur_q.pos_x, dx_q);
		ny = adv(cur_q.pos_y, dy_q);
		nvx = cur_q.vel_x;
		nvy = cur_q.vel_y;
		if ($signed({nx[PW-1], nx}) < lo) begin nx = lo[PW-1:0]; nvx = neg_sat(nvx); end
		if ($signed({nx[PW-1], nx}) > hi) begin nx = hi[PW-1:0]; nvx = neg_sat(nvx); end
		if ($signed({ny[PW-1], ny}) < lo) begin ny = lo[PW-1:0]; nvy = neg_sat(nvy); end
		if ($signed({ny[PW-1], ny}) > hi) begin ny = hi[PW-1:0]; nvy = neg_sat(nvy); end
		add_sum = {1'b0, sum_q} + {1'b0, quo[EW-1:0]};
		sum_nx = sum_q;
		ovf_nx = ovf_q;
		if (!cur_q.immovable) begin
			if (quo[pes_pkg::SQ_W-1:EW] != '0 || add_sum[EW]) begin
				sum_nx = '1;
				ovf_nx = 1'b1;
			end else begin
				sum_nx = add_sum[EW-1:0];
			end
		end
	end

	// products, item capture and output registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) cur_q <= item;
		if (state_q == pes_pkg::ST_MUL) begin
			dx_q <= cur_q.vel_x * $signed({1'b0, time_step});
			dy_q <= cur_q.vel_y * $signed({1'b0, time_step});
			sq_x_q <= ax * ax;
			sq_y_q <= ay * ay;
		end
		if (out_take) begin
			o_px_q <= nx;
			o_py_q <= ny;
			o_vx_q <= nvx;
			o_vy_q <= nvy;
			o_en_q <= cur_q.last_particle ? sum_nx : '0;
			o_ev_q <= cur_q.last_particle;
			o_es_q <= cur_q.last_particle && ovf_nx;
		end
	end

	// control state, running sum and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pes_pkg::ST_IDLE;
			sum_q <= '0;
			ovf_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_take) begin
				sum_q <= cur_q.last_particle ? '0 : sum_nx;
				ovf_q <= cur_q.last_particle ? 1'b0 : ovf_nx;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	assign m_tdata = {o_en_q, o_vy_q, o_vx_q, o_py_q, o_px_q};
	assign m_tuser = {o_es_q, o_ev_q};

	ast_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == pes_pkg::ST_DIV)) else $error("divider out of step");
	ast_take_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_take |=> m_tvalid) else $error("result dropped");
	ast_sat_has_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tuser[1] |-> m_tuser[0]) else $error("saturation without energy");

endmodule
